>>> design/ptpsod_pkg.sv
// shared types, codes and constants of the ptp slave offset/delay engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptpsod_pkg;

    localparam int TICK_MS_DEF = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int TIMER_MAX   = 127;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [3:0]  CFG_RESET  = 4'hD;

    localparam logic [1:0] MODE_TICK           = 2'd0;
    localparam logic [1:0] MODE_SYNC           = 2'd1;
    localparam logic [1:0] MODE_PRECISE_ORIGIN = 2'd2;
    localparam logic [1:0] MODE_DELAY_REPLY    = 2'd3;

    localparam logic [1:0] ST_LISTENING    = 2'd0;
    localparam logic [1:0] ST_UNCALIBRATED = 2'd1;
    localparam logic [1:0] ST_SLAVE        = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] local_ns;
        logic [63:0] stamp_ns;
    } t_event;

    typedef struct packed {
        logic [1:0]  port_state;
        logic        send_delay_req;
        logic [15:0] request_sequence;
        logic        measurement_valid;
        logic [63:0] offset;
        logic [63:0] mean_delay;
        logic [31:0] sync_total;
        logic [31:0] request_total;
    } t_result;

    function automatic logic [6:0] sat_reload(input int r);
        logic [6:0] v;
        v = (r > TIMER_MAX) ? 7'(TIMER_MAX) : 7'(r);
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/ptpsod_fifo.sv
// small register queue used between front and back and for results
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module ptpsod_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> design/ptpsod_front.sv
// front end: accepts events, converts the master stamp to nanoseconds
// depends on ptpsod_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpsod_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_local_time_ns,
    input  wire logic [31:0] i_stamp_seconds,
    input  wire logic [29:0] i_stamp_nanoseconds,
    output logic             o_ev_push,
    output ptpsod_pkg::t_event o_ev,
    input  wire logic        i_ev_full
);

    logic        r_v1, r_v2;
    logic [1:0]  r1_mode, r2_mode;
    logic [63:0] r1_local, r2_local;
    logic [31:0] r1_sec;
    logic [29:0] r1_nsec, r2_nsec;
    logic [61:0] r2_prod;
    logic        w_adv1, w_adv2, w_take;

    assign w_adv2 = r_v2 && !i_ev_full;
    assign w_adv1 = r_v1 && (!r_v2 || w_adv2);
    assign o_full = r_v1 && !w_adv1;
    assign w_take = i_push && !o_full;

    assign o_ev_push      = r_v2;
    assign o_ev.mode      = r2_mode;
    assign o_ev.local_ns  = r2_local;
    assign o_ev.stamp_ns  = 64'(r2_prod) + 64'(r2_nsec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_take) begin
                r_v1 <= 1'b1;
            end else if (w_adv1) begin
                r_v1 <= 1'b0;
            end
            if (w_adv1) begin
                r_v2 <= 1'b1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r1_mode  <= i_mode;
            r1_local <= i_local_time_ns;
            r1_sec   <= i_stamp_seconds;
            r1_nsec  <= i_stamp_nanoseconds;
        end
        if (w_adv1) begin
            r2_mode  <= r1_mode;
            r2_local <= r1_local;
            r2_nsec  <= r1_nsec;
            r2_prod  <= 62'(r1_sec) * 62'(ptpsod_pkg::NS_PER_SEC);
        end
    end

endmodule

`default_nettype wire

>>> design/ptpsod_back.sv
// back end: port state, delay request timer and offset/delay measurement
// depends on ptpsod_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpsod_back #(
    parameter int TICK_MS = ptpsod_pkg::TICK_MS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire ptpsod_pkg::t_event i_ev,
    input  wire logic        i_ev_empty,
    output logic             o_ev_pop,
    output logic             o_res_push,
    output ptpsod_pkg::t_result o_res,
    input  wire logic        i_res_full
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SUM  = 2'd1;
    localparam logic [1:0] PH_OFS  = 2'd2;

    localparam logic [6:0] RELOAD_TAB [0:8] = '{
        ptpsod_pkg::sat_reload((1000 >> 0) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 1) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 2) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 3) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 4) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 5) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 6) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 7) / TICK_MS),
        ptpsod_pkg::sat_reload((1000 >> 8) / TICK_MS)
    };

    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_cfg;
    logic [1:0]  r_state, n_state;
    logic [6:0]  r_timer, n_timer;
    logic [15:0] r_seq, n_seq;
    logic [63:0] r_t1, n_t1, r_t2, n_t2, r_t3, n_t3;
    logic [63:0] r_offset, n_offset, r_mean, n_mean;
    logic [31:0] r_syncs, n_syncs, r_reqs, n_reqs;
    logic [63:0] r_fwd, r_rev, r_half;
    logic [63:0] w_sum;
    logic [3:0]  w_shift;
    logic        w_send;
    logic [15:0] w_seq;
    logic        w_valid;
    logic        w_load_diff;

    assign w_shift = r_cfg[3] ? 4'(5'd16 - {1'b0, r_cfg}) : 4'd0;
    assign w_sum   = r_fwd + r_rev;

    always_comb begin
        n_phase     = r_phase;
        n_state     = r_state;
        n_timer     = r_timer;
        n_seq       = r_seq;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_t3        = r_t3;
        n_offset    = r_offset;
        n_mean      = r_mean;
        n_syncs     = r_syncs;
        n_reqs      = r_reqs;
        o_ev_pop    = 1'b0;
        o_res_push  = 1'b0;
        w_send      = 1'b0;
        w_seq       = '0;
        w_valid     = 1'b0;
        w_load_diff = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (!i_ev_empty) begin
                    if (i_ev.mode == ptpsod_pkg::MODE_DELAY_REPLY) begin
                        o_ev_pop    = 1'b1;
                        w_load_diff = 1'b1;
                        n_phase     = PH_SUM;
                    end else if (!i_res_full) begin
                        o_ev_pop   = 1'b1;
                        o_res_push = 1'b1;
                        unique case (i_ev.mode)
                            ptpsod_pkg::MODE_TICK: begin
                                if (r_state != ptpsod_pkg::ST_LISTENING) begin
                                    if (r_timer != '0) begin
                                        n_timer = 7'(r_timer - 1'b1);
                                    end else begin
                                        w_send  = 1'b1;
                                        w_seq   = r_seq;
                                        n_seq   = 16'(r_seq + 1'b1);
                                        n_t3    = i_ev.local_ns;
                                        n_reqs  = 32'(r_reqs + 1'b1);
                                        n_timer = RELOAD_TAB[w_shift];
                                    end
                                end
                            end
                            ptpsod_pkg::MODE_SYNC: begin
                                n_t2    = i_ev.local_ns;
                                n_syncs = 32'(r_syncs + 1'b1);
                                if (r_state == ptpsod_pkg::ST_LISTENING) begin
                                    n_state = ptpsod_pkg::ST_UNCALIBRATED;
                                end
                            end
                            default: begin
                                n_t1 = i_ev.stamp_ns;
                            end
                        endcase
                    end
                end
            end
            PH_SUM: begin
                n_phase = PH_OFS;
            end
            PH_OFS: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    w_valid    = 1'b1;
                    n_mean     = r_half;
                    n_offset   = r_fwd - r_half;
                    n_phase    = PH_IDLE;
                    if (r_state == ptpsod_pkg::ST_UNCALIBRATED) begin
                        n_state = ptpsod_pkg::ST_SLAVE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_res.port_state        = n_state;
    assign o_res.send_delay_req    = w_send;
    assign o_res.request_sequence  = w_seq;
    assign o_res.measurement_valid = w_valid;
    assign o_res.offset            = n_offset;
    assign o_res.mean_delay        = n_mean;
    assign o_res.sync_total        = n_syncs;
    assign o_res.request_total     = n_reqs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cfg    <= ptpsod_pkg::CFG_RESET;
            r_state  <= ptpsod_pkg::ST_LISTENING;
            r_timer  <= '0;
            r_seq    <= '0;
            r_t1     <= '0;
            r_t2     <= '0;
            r_t3     <= '0;
            r_offset <= '0;
            r_mean   <= '0;
            r_syncs  <= '0;
            r_reqs   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_state  <= n_state;
            r_timer  <= n_timer;
            r_seq    <= n_seq;
            r_t1     <= n_t1;
            r_t2     <= n_t2;
            r_t3     <= n_t3;
            r_offset <= n_offset;
            r_mean   <= n_mean;
            r_syncs  <= n_syncs;
            r_reqs   <= n_reqs;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // half toward zero: add one to negative sums before the arithmetic shift
    always_ff @(posedge i_clk) begin
        if (w_load_diff) begin
            r_fwd <= r_t2 - r_t1;
            r_rev <= i_ev.stamp_ns - r_t3;
        end
        if (r_phase == PH_SUM) begin
            r_half <= 64'($signed(w_sum + 64'(w_sum[63])) >>> 1);
        end
    end

endmodule

`default_nettype wire

>>> design/ptp_slave_offset_delay_engine_core.sv
// ptp slave offset and delay engine, top level
// depends on ptpsod_pkg, ptpsod_fifo, ptpsod_front, ptpsod_back
//
// events (tick, sync, follow-up, delay response) enter through push/full; a
// word is taken at a clock edge with push high and full low. every event gives
// exactly one result word, read through empty/pop in event order.
// the front registers the event and forms the master stamp as
// seconds*1e9+ns (one 32x30 multiply, registered before the add), then
// hands it to a two-word queue. the back executes tick, sync and follow-up
// in its idle phase and a delay response in the phases difference, halved
// sum and offset. throughput: one event per cycle while the result queue
// has space; the back takes no new event while a delay response is in progress.
// the delay request interval register is written with i_cfg_we, taking
// effect on the next timer reload.
// reset clears port state, timer, sequence, timestamps, measurements,
// counters and both queues; the interval register returns to -3.
// a stalled receiver fills the result queue, then the event queue, then
// the front stages, after which full stays high until pop frees space.
`timescale 1ns / 1ps
`default_nettype none

module ptp_slave_offset_delay_engine_core #(
    parameter int TICK_MS = ptpsod_pkg::TICK_MS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_mode,
    input  wire logic [63:0] i_local_time_ns,
    input  wire logic [31:0] i_stamp_seconds,
    input  wire logic [29:0] i_stamp_nanoseconds,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_port_state,
    output logic             o_send_delay_req,
    output logic [15:0]      o_request_sequence,
    output logic             o_measurement_valid,
    output logic signed [63:0] o_offset,
    output logic signed [63:0] o_mean_delay,
    output logic [31:0]      o_sync_total,
    output logic [31:0]      o_request_total
);

    localparam int EV_W  = $bits(ptpsod_pkg::t_event);
    localparam int RES_W = $bits(ptpsod_pkg::t_result);

    ptpsod_pkg::t_event  w_front_ev, w_back_ev;
    ptpsod_pkg::t_result w_back_res, w_out_res;
    logic                w_front_push, w_ev_full, w_ev_empty, w_ev_pop;
    logic                w_res_push, w_res_full;

    ptpsod_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_mode             (i_mode),
        .i_local_time_ns    (i_local_time_ns),
        .i_stamp_seconds    (i_stamp_seconds),
        .i_stamp_nanoseconds(i_stamp_nanoseconds),
        .o_ev_push          (w_front_push),
        .o_ev               (w_front_ev),
        .i_ev_full          (w_ev_full)
    );

    ptpsod_fifo #(
        .WIDTH(EV_W),
        .DEPTH(ptpsod_pkg::QUEUE_DEPTH)
    ) u_ev_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_front_push),
        .i_data (w_front_ev),
        .o_full (w_ev_full),
        .i_pop  (w_ev_pop),
        .o_data (w_back_ev),
        .o_empty(w_ev_empty)
    );

    ptpsod_back #(
        .TICK_MS(TICK_MS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_ev       (w_back_ev),
        .i_ev_empty (w_ev_empty),
        .o_ev_pop   (w_ev_pop),
        .o_res_push (w_res_push),
        .o_res      (w_back_res),
        .i_res_full (w_res_full)
    );

    ptpsod_fifo #(
        .WIDTH(RES_W),
        .DEPTH(ptpsod_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_back_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_out_res),
        .o_empty(empty)
    );

    assign o_port_state        = w_out_res.port_state;
    assign o_send_delay_req    = w_out_res.send_delay_req;
    assign o_request_sequence  = w_out_res.request_sequence;
    assign o_measurement_valid = w_out_res.measurement_valid;
    assign o_offset            = $signed(w_out_res.offset);
    assign o_mean_delay        = $signed(w_out_res.mean_delay);
    assign o_sync_total        = w_out_res.sync_total;
    assign o_request_total     = w_out_res.request_total;

endmodule

`default_nettype wire

>>> tb/sv/ptp_slave_offset_delay_engine_core_tb.sv
// self-checking testbench for ptp_slave_offset_delay_engine_core
// depends on ptpsod_pkg and the core; keeps its own copy of port state, timer,
// timestamps and counters and checks every result word in order
`timescale 1ns / 1ps

module ptp_slave_offset_delay_engine_core_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 220;

    localparam logic [1:0] M_TICK = ptpsod_pkg::MODE_TICK;
    localparam logic [1:0] M_SYNC = ptpsod_pkg::MODE_SYNC;
    localparam logic [1:0] M_ORIG = ptpsod_pkg::MODE_PRECISE_ORIGIN;
    localparam logic [1:0] M_RPLY = ptpsod_pkg::MODE_DELAY_REPLY;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_wdata;
    logic        push;
    logic        full;
    logic [1:0]  i_mode;
    logic [63:0] i_local_time_ns;
    logic [31:0] i_stamp_seconds;
    logic [29:0] i_stamp_nanoseconds;
    logic        empty;
    logic        pop;
    logic [1:0]  o_port_state;
    logic        o_send_delay_req;
    logic [15:0] o_request_sequence;
    logic        o_measurement_valid;
    logic signed [63:0] o_offset;
    logic signed [63:0] o_mean_delay;
    logic [31:0] o_sync_total;
    logic [31:0] o_request_total;

    // predicted engine state
    logic [3:0]  interval_log;
    logic [1:0]  port_state_q;
    logic [6:0]  request_timer_q;
    logic [15:0] next_seq_q;
    logic [63:0] t1_ns, t2_ns, t3_ns, t4_ns;
    logic [63:0] offset_q, mean_delay_q;
    logic [31:0] sync_count_q, request_count_q;

    ptpsod_pkg::t_result expected_words[$];
    ptpsod_pkg::t_result head_word;
    int error_count;
    int cycle_count;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;

    ptp_slave_offset_delay_engine_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .push                (push),
        .full                (full),
        .i_mode              (i_mode),
        .i_local_time_ns     (i_local_time_ns),
        .i_stamp_seconds     (i_stamp_seconds),
        .i_stamp_nanoseconds (i_stamp_nanoseconds),
        .empty               (empty),
        .pop                 (pop),
        .o_port_state        (o_port_state),
        .o_send_delay_req    (o_send_delay_req),
        .o_request_sequence  (o_request_sequence),
        .o_measurement_valid (o_measurement_valid),
        .o_offset            (o_offset),
        .o_mean_delay        (o_mean_delay),
        .o_sync_total        (o_sync_total),
        .o_request_total     (o_request_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ptp_slave_offset_delay_engine_core_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [6:0] interval_reload(input logic [3:0] lg);
        int shift;
        int r;
        shift = lg[3] ? 16 - int'(lg) : 0;
        r = (1000 >> shift) / ptpsod_pkg::TICK_MS_DEF;
        if (r > ptpsod_pkg::TIMER_MAX) r = ptpsod_pkg::TIMER_MAX;
        return 7'(r);
    endfunction

    function automatic logic [63:0] stamp_total_ns(input logic [31:0] s, input logic [29:0] n);
        return {32'd0, s} * 64'd1000000000 + {34'd0, n};
    endfunction

    task automatic predict_event(input logic [1:0] m, input logic [63:0] lt,
                                 input logic [31:0] s, input logic [29:0] n);
        ptpsod_pkg::t_result r;
        logic [63:0] fwd, rev, total;
        r = '0;
        case (m)
            M_TICK: begin
                if (port_state_q == ptpsod_pkg::ST_UNCALIBRATED ||
                    port_state_q == ptpsod_pkg::ST_SLAVE) begin
                    if (request_timer_q != 7'd0) begin
                        request_timer_q = request_timer_q - 7'd1;
                    end else begin
                        r.send_delay_req = 1'b1;
                        r.request_sequence = next_seq_q;
                        next_seq_q = next_seq_q + 16'd1;
                        t3_ns = lt;
                        request_count_q = request_count_q + 32'd1;
                        request_timer_q = interval_reload(interval_log);
                    end
                end
            end
            M_SYNC: begin
                t2_ns = lt;
                if (port_state_q == ptpsod_pkg::ST_LISTENING) begin
                    port_state_q = ptpsod_pkg::ST_UNCALIBRATED;
                end
                sync_count_q = sync_count_q + 32'd1;
            end
            M_ORIG: begin
                t1_ns = stamp_total_ns(s, n);
            end
            default: begin
                t4_ns = stamp_total_ns(s, n);
                fwd = t2_ns - t1_ns;
                rev = t4_ns - t3_ns;
                total = fwd + rev;
                mean_delay_q = total[63] ? -((-total) >> 1) : (total >> 1);
                offset_q = fwd - mean_delay_q;
                r.measurement_valid = 1'b1;
                if (port_state_q == ptpsod_pkg::ST_UNCALIBRATED) begin
                    port_state_q = ptpsod_pkg::ST_SLAVE;
                end
            end
        endcase
        r.port_state = port_state_q;
        r.offset = offset_q;
        r.mean_delay = mean_delay_q;
        r.sync_total = sync_count_q;
        r.request_total = request_count_q;
        expected_words.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                head_word = expected_words.pop_front();
                check_field("port_state", head_word.port_state, o_port_state);
                check_field("send_delay_req", head_word.send_delay_req, o_send_delay_req);
                check_field("request_sequence", head_word.request_sequence,
                            o_request_sequence);
                check_field("measurement_valid", head_word.measurement_valid,
                            o_measurement_valid);
                check_field("offset", head_word.offset, o_offset);
                check_field("mean_delay", head_word.mean_delay, o_mean_delay);
                check_field("sync_total", head_word.sync_total, o_sync_total);
                check_field("request_total", head_word.request_total, o_request_total);
            end
        end
    end

    always @(negedge i_clk) begin
        pop = ($urandom_range(99, 0) >= recv_stall_pct);
    end

    task automatic send_word(input logic [1:0] m, input logic [63:0] lt,
                             input logic [31:0] s, input logic [29:0] n);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_mode = m;
        i_local_time_ns = lt;
        i_stamp_seconds = s;
        i_stamp_nanoseconds = n;
        do @(posedge i_clk); while (full);
        predict_event(m, lt, s, n);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        push = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [3:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        interval_log = v;
    endtask

    function automatic logic [29:0] random_ns();
        if ($urandom_range(7, 0) == 0) return 30'($urandom);
        return 30'($urandom_range(999999999, 0));
    endfunction

    function automatic logic [63:0] random_local(input logic [63:0] base);
        if ($urandom_range(3, 0) == 0) return {$urandom, $urandom};
        return base + 64'($urandom_range(200000, 0)) - 64'd100000;
    endfunction

    // events before any sync: nothing moves but the measurement and the origin stamp
    task automatic test_listening_events();
        send_word(M_TICK, 64'd0, 32'd0, 30'd0);
        send_word(M_RPLY, '1, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_word(M_ORIG, 64'd0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_word(M_TICK, '1, 32'd0, 30'd0);
    endtask

    // first sync, then the reset interval drives the request spacing
    task automatic test_default_interval();
        send_word(M_SYNC, '1, 32'd0, 30'd0);
        for (int k = 0; k < 14; k++) send_word(M_TICK, {$urandom, $urandom}, 32'd0, 30'd0);
    endtask

    task automatic test_measurement_math();
        write_interval(4'h9);
        send_word(M_TICK, 64'd0, 32'd0, 30'd0);
        send_word(M_RPLY, 64'd0, 32'd0, 30'd0);
        send_word(M_ORIG, 64'd0, 32'd0, 30'd10);
        send_word(M_SYNC, 64'd5, 32'd0, 30'd0);
        send_word(M_TICK, 64'd100, 32'd0, 30'd0);
        // delay responses one nanosecond apart: one of the two sums is odd
        send_word(M_RPLY, 64'd0, 32'd0, 30'd100);
        send_word(M_RPLY, 64'd0, 32'd0, 30'd99);
        send_word(M_SYNC, 64'h8000_0000_0000_0000, 32'd0, 30'd0);
        send_word(M_ORIG, 64'd0, 32'd0, 30'd0);
        send_word(M_RPLY, 64'd0, 32'd0, 30'd100);
        send_word(M_TICK, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 30'd0);
        send_word(M_RPLY, 64'd0, 32'h8000_0000, 30'd999999999);
        send_word(M_ORIG, 64'd0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_word(M_RPLY, 64'd0, 32'd1, 30'd0);
    endtask

    // out-of-range interval codes: positive and most negative
    task automatic test_interval_extremes();
        write_interval(4'h8);
        for (int k = 0; k < 4; k++) send_word(M_TICK, {$urandom, $urandom}, 32'd0, 30'd0);
        write_interval(4'h7);
        for (int k = 0; k < 103; k++) send_word(M_TICK, {$urandom, $urandom}, 32'd0, 30'd0);
    endtask

    // shortest interval: once the timer left from before runs out, a request on every tick, back to back
    task automatic test_request_every_tick();
        write_interval(4'h9);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 40; k++) begin
            send_word(M_TICK, {$urandom, $urandom}, $urandom, random_ns());
        end
    endtask

    task automatic run_exchange();
        logic [31:0] sec;
        logic [29:0] nsv;
        logic [63:0] t1;
        int n_ticks;
        sec = $urandom;
        nsv = random_ns();
        t1 = stamp_total_ns(sec, nsv);
        n_ticks = ($urandom_range(9, 0) == 0) ? $urandom_range(110, 0) : $urandom_range(6, 0);
        send_word(M_SYNC, random_local(t1), $urandom, random_ns());
        if ($urandom_range(9, 0) != 0) send_word(M_ORIG, {$urandom, $urandom}, sec, nsv);
        for (int k = 0; k < n_ticks; k++) begin
            send_word(M_TICK, random_local(t1), $urandom, random_ns());
        end
        if ($urandom_range(9, 0) != 0) begin
            send_word(M_RPLY, {$urandom, $urandom},
                      ($urandom_range(3, 0) == 0) ? $urandom : sec, random_ns());
        end
    endtask

    task automatic test_random_traffic(input logic [3:0] lg, input int send_pct,
                                       input int recv_pct);
        int goal;
        write_interval(lg);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            if ($urandom_range(4, 0) == 0) begin
                send_word(2'($urandom_range(3, 0)), {$urandom, $urandom}, $urandom,
                          random_ns());
            end else begin
                run_exchange();
            end
        end
    endtask

    logic [3:0] phase_log[8] = '{4'hD, 4'h0, 4'hF, 4'hE, 4'hC, 4'hB, 4'hA, 4'h9};
    int phase_send[4] = '{0, 48, 0, 32};
    int phase_recv[4] = '{0, 0, 48, 32};

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 4'd0;
        push = 1'b0;
        pop = 1'b0;
        i_mode = M_TICK;
        i_local_time_ns = 64'd0;
        i_stamp_seconds = 32'd0;
        i_stamp_nanoseconds = 30'd0;
        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        interval_log = ptpsod_pkg::CFG_RESET;
        port_state_q = ptpsod_pkg::ST_LISTENING;
        request_timer_q = 7'd0;
        next_seq_q = 16'd0;
        t1_ns = 64'd0;
        t2_ns = 64'd0;
        t3_ns = 64'd0;
        t4_ns = 64'd0;
        offset_q = 64'd0;
        mean_delay_q = 64'd0;
        sync_count_q = 32'd0;
        request_count_q = 32'd0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_listening_events();
        test_default_interval();
        test_measurement_math();
        test_interval_extremes();
        test_request_every_tick();
        for (int p = 0; p < 8; p++) begin
            test_random_traffic(phase_log[p], phase_send[p % 4], phase_recv[p % 4]);
        end
        drain_results();

        if (error_count == 0) begin
            $display("ptp_slave_offset_delay_engine_core_tb: done, clean");
        end else begin
            $display("ptp_slave_offset_delay_engine_core_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> ptp_slave_offset_delay_engine_core.f
design/ptpsod_pkg.sv
design/ptpsod_fifo.sv
design/ptpsod_front.sv
design/ptpsod_back.sv
design/ptp_slave_offset_delay_engine_core.sv
tb/sv/ptp_slave_offset_delay_engine_core_tb.sv
